@@ hw/rtl/hrbt_pkg.sv @@
// ----------------------------------------------------------------------------
// hrbt_pkg: shared types and constants of the heart rate beat tracker
// Field widths, state and code enums, divider request/response bundles.
// ----------------------------------------------------------------------------
package hrbt_pkg;

  // field widths
  localparam int TS_W       = 32;
  localparam int CNT_W      = $clog2(TS_W);
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = $clog2(CFG_W);
  localparam int BPM_W      = 8;
  localparam int CIDX_W     = 3;

  // shared divider geometry
  localparam int DIVD_W     = 16;
  localparam int DIVS_W     = 12;
  localparam int QUO_W      = 8;
  localparam int STEP_W     = $clog2(QUO_W);
  localparam int DSH_W      = DIVS_W + QUO_W - 1;

  // configuration reset values
  localparam logic [CFG_W-1:0] REFRACTORY_RST  = 16'd350;
  localparam logic [CFG_W-1:0] WINDOW_RST      = 16'd60000;
  localparam logic [CFG_W-1:0] RESTART_GAP_RST = 16'd3000;
  localparam logic [BPM_W-1:0] HIGH_LIMIT_RST  = 8'd110;
  localparam logic [BPM_W-1:0] LOW_LIMIT_RST   = 8'd50;

  // rate arithmetic constants
  localparam logic [DIVD_W-1:0] RATE_NUMER   = 16'd60000;
  localparam logic [CFG_W-1:0]  RATE_MIN_IV  = 16'd236;
  localparam logic [CFG_W-1:0]  RATE_LIM_IV  = 16'd3000;
  localparam logic [BPM_W-1:0]  CLASS_FLOOR  = 8'd20;
  localparam logic [BPM_W-1:0]  CLASS_CEIL   = 8'd225;
  localparam logic [BPM_W-1:0]  COUNT_MAX    = 8'd255;

  typedef enum logic [1:0] {
    ACT_BEAT    = 2'd0,
    ACT_COUNT   = 2'd1,
    ACT_AVERAGE = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    MODE_STANDBY = 2'd0,
    MODE_COUNT   = 2'd1,
    MODE_AVERAGE = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    CLS_NONE   = 2'd0,
    CLS_NORMAL = 2'd1,
    CLS_FAST   = 2'd2,
    CLS_SLOW   = 2'd3
  } rate_class_t;

  typedef enum logic [CIDX_W-1:0] {
    CFG_REFRACTORY  = 3'd0,
    CFG_WINDOW      = 3'd1,
    CFG_RESTART_GAP = 3'd2,
    CFG_HIGH_LIMIT  = 3'd3,
    CFG_LOW_LIMIT   = 3'd4
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_APPLY,
    ST_DIV_RATE,
    ST_RING,
    ST_DIV_MEAN,
    ST_FINISH
  } seq_state_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

endpackage

@@ hw/rtl/hrbt_bit_sub.sv @@
// ----------------------------------------------------------------------------
// hrbt_bit_sub: bit-serial subtract cell
// Takes a and b one bit per step, lsb first; keeps the borrow in a flop.
// ----------------------------------------------------------------------------
module hrbt_bit_sub (
  input  logic clk,
  input  logic rst_n,
  input  logic clear,
  input  logic step,
  input  logic a,
  input  logic b,
  output logic diff,
  output logic borrow
);

  logic borrow_r;
  logic borrow_nxt;

  // full subtractor on the current bit
  assign diff       = a ^ b ^ borrow_r;
  assign borrow_nxt = (~a & b) | (~(a ^ b) & borrow_r);
  assign borrow     = borrow_r;

  // borrow flop, cleared by clear before each serial operation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      borrow_r <= 1'b0;
    end else if (clear) begin
      borrow_r <= 1'b0;
    end else if (step) begin
      borrow_r <= borrow_nxt;
    end
  end

endmodule

@@ hw/rtl/hrbt_divider.sv @@
// ----------------------------------------------------------------------------
// hrbt_divider: shared restoring divider
// One quotient bit per cycle; the quotient must fit in QUO_W bits.
// ----------------------------------------------------------------------------
module hrbt_divider
  import hrbt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIVD_W-1:0] rem_r, rem_nxt;
  logic [DSH_W-1:0]  dsh_r, dsh_nxt;
  logic [QUO_W-1:0]  quo_r, quo_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              fits;

  // trial subtract of the shifted divisor
  assign fits = DSH_W'(rem_r) >= dsh_r;

  always_comb begin
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    quo_nxt  = quo_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = req.dividend;
      dsh_nxt  = DSH_W'(req.divisor) << (QUO_W - 1);
      quo_nxt  = '0;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (fits) begin
        rem_nxt = rem_r - dsh_r[DIVD_W-1:0];
      end
      quo_nxt  = {quo_r[QUO_W-2:0], fits};
      dsh_nxt  = dsh_r >> 1;
      step_nxt = step_r + STEP_W'(1);
      if (step_r == STEP_W'(QUO_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    dsh_r  <= dsh_nxt;
    quo_r  <= quo_nxt;
    step_r <= step_nxt;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

@@ hw/rtl/heart_rate_beat_tracker.sv @@
// ----------------------------------------------------------------------------
// heart_rate_beat_tracker: beat interval tracker with count and average modes
// Each input is shifted through the bit-serial interval subtract and compares,
// then applied; an average-mode beat that stores a rate also makes two passes
// through the shared divider (rate, then mean of the ring). in_stall holds new
// input off until the result register is loaded and the sequencer is idle.
// Reset: synchronous, active low; registers, state and rate ring to defaults.
// ----------------------------------------------------------------------------
module heart_rate_beat_tracker
  import hrbt_pkg::*;
#(
  parameter int RING_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_action,
  input  logic [TS_W-1:0]   in_timestamp_ms,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_mode,
  output logic              out_beat_accepted,
  output logic [TS_W-1:0]   out_interval_ms,
  output logic              out_measuring,
  output logic              out_window_done,
  output logic              out_window_closed_now,
  output logic [BPM_W-1:0]  out_running_count,
  output logic [BPM_W-1:0]  out_window_total,
  output logic [BPM_W-1:0]  out_average_bpm,
  output logic [1:0]        out_rate_class,
  // configuration
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  localparam int POS_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int SUM_W = BPM_W + $clog2(RING_DEPTH);

  // configuration registers
  logic [CFG_W-1:0] refr_r, window_r, gap_r;
  logic [BPM_W-1:0] high_r, low_r;

  // sequencer
  seq_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [1:0]       act_r, act_nxt;
  logic [TS_W-1:0]  ts_sh_r, ts_sh_nxt;
  logic [TS_W-1:0]  lb_sh_r, lb_sh_nxt;
  logic [TS_W-1:0]  ws_sh_r, ws_sh_nxt;
  logic [TS_W-1:0]  iv_sh_r, iv_sh_nxt;
  logic             acc_r, acc_nxt;
  logic             closed_r, closed_nxt;

  // tracker state
  mode_t            mode_r, mode_nxt;
  logic             await_r, await_nxt;
  logic             meas_r, meas_nxt;
  logic             fin_r, fin_nxt;
  logic [TS_W-1:0]  last_beat_r, last_beat_nxt;
  logic [TS_W-1:0]  last_iv_r, last_iv_nxt;
  logic [TS_W-1:0]  win_start_r, win_start_nxt;
  logic [BPM_W-1:0] cnt_r, cnt_nxt;
  logic [BPM_W-1:0] total_r, total_nxt;
  logic [BPM_W-1:0] mean_r, mean_nxt;
  logic [BPM_W-1:0] ring_r [RING_DEPTH];
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic             ring_we;

  // output register
  logic              out_valid_r;
  logic              out_load;
  logic [1:0]        out_mode_r;
  logic              out_acc_r, out_meas_r, out_done_r, out_closed_r;
  logic [TS_W-1:0]   out_iv_r;
  logic [BPM_W-1:0]  out_cnt_r, out_total_r, out_mean_r;
  rate_class_t       out_cls_r, cls_c;

  // serial datapath
  logic       accept, step;
  logic       refr_bit, win_bit, gap_bit, min_bit, lim_bit;
  logic       iv_bit, el_bit;
  logic       refr_bw, win_bw, gap_bw, min_bw, lim_bw;
  div_req_t   div_req;
  div_rsp_t   div_rsp;

  assign accept   = (state_r == ST_IDLE) && in_valid;
  assign step     = (state_r == ST_SHIFT);
  assign in_stall = (state_r != ST_IDLE);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      refr_r   <= REFRACTORY_RST;
      window_r <= WINDOW_RST;
      gap_r    <= RESTART_GAP_RST;
      high_r   <= HIGH_LIMIT_RST;
      low_r    <= LOW_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REFRACTORY:  refr_r   <= cfg_wdata;
        CFG_WINDOW:      window_r <= cfg_wdata;
        CFG_RESTART_GAP: gap_r    <= cfg_wdata;
        CFG_HIGH_LIMIT:  high_r   <= cfg_wdata[BPM_W-1:0];
        CFG_LOW_LIMIT:   low_r    <= cfg_wdata[BPM_W-1:0];
        default: ;
      endcase
    end
  end

  // compare operands, one bit per step, zero above the 16-bit fields
  always_comb begin
    refr_bit = 1'b0;
    win_bit  = 1'b0;
    gap_bit  = 1'b0;
    min_bit  = 1'b0;
    lim_bit  = 1'b0;
    if (bit_cnt_r < CNT_W'(CFG_W)) begin
      refr_bit = refr_r[bit_cnt_r[CFG_IDX_W-1:0]];
      win_bit  = window_r[bit_cnt_r[CFG_IDX_W-1:0]];
      gap_bit  = gap_r[bit_cnt_r[CFG_IDX_W-1:0]];
      min_bit  = RATE_MIN_IV[bit_cnt_r[CFG_IDX_W-1:0]];
      lim_bit  = RATE_LIM_IV[bit_cnt_r[CFG_IDX_W-1:0]];
    end
  end

  // interval and elapsed time, then their compares, all lsb first
  hrbt_bit_sub u_iv_sub (
    .clk(clk), .rst_n(rst_n), .clear(accept), .step(step),
    .a(ts_sh_r[0]), .b(lb_sh_r[0]), .diff(iv_bit), .borrow()
  );
  hrbt_bit_sub u_el_sub (
    .clk(clk), .rst_n(rst_n), .clear(accept), .step(step),
    .a(ts_sh_r[0]), .b(ws_sh_r[0]), .diff(el_bit), .borrow()
  );
  hrbt_bit_sub u_refr_cmp (
    .clk(clk), .rst_n(rst_n), .clear(accept), .step(step),
    .a(iv_bit), .b(refr_bit), .diff(), .borrow(refr_bw)
  );
  hrbt_bit_sub u_win_cmp (
    .clk(clk), .rst_n(rst_n), .clear(accept), .step(step),
    .a(el_bit), .b(win_bit), .diff(), .borrow(win_bw)
  );
  hrbt_bit_sub u_gap_cmp (
    .clk(clk), .rst_n(rst_n), .clear(accept), .step(step),
    .a(iv_bit), .b(gap_bit), .diff(), .borrow(gap_bw)
  );
  hrbt_bit_sub u_min_cmp (
    .clk(clk), .rst_n(rst_n), .clear(accept), .step(step),
    .a(iv_bit), .b(min_bit), .diff(), .borrow(min_bw)
  );
  hrbt_bit_sub u_lim_cmp (
    .clk(clk), .rst_n(rst_n), .clear(accept), .step(step),
    .a(iv_bit), .b(lim_bit), .diff(), .borrow(lim_bw)
  );

  // shared divider: rate from interval, then mean of the ring
  hrbt_divider u_divider (
    .clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp)
  );

  // running sum with the slot being replaced swapped out
  assign sum_nxt = sum_r - SUM_W'(ring_r[pos_r]) + SUM_W'(div_rsp.quotient);

  // sequencer and tracker update
  always_comb begin
    state_nxt     = state_r;
    bit_cnt_nxt   = bit_cnt_r;
    act_nxt       = act_r;
    ts_sh_nxt     = ts_sh_r;
    lb_sh_nxt     = lb_sh_r;
    ws_sh_nxt     = ws_sh_r;
    iv_sh_nxt     = iv_sh_r;
    acc_nxt       = acc_r;
    closed_nxt    = closed_r;
    mode_nxt      = mode_r;
    await_nxt     = await_r;
    meas_nxt      = meas_r;
    fin_nxt       = fin_r;
    last_beat_nxt = last_beat_r;
    last_iv_nxt   = last_iv_r;
    win_start_nxt = win_start_r;
    cnt_nxt       = cnt_r;
    total_nxt     = total_r;
    mean_nxt      = mean_r;
    pos_nxt       = pos_r;
    ring_we       = 1'b0;
    div_req       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          act_nxt     = in_action;
          ts_sh_nxt   = in_timestamp_ms;
          lb_sh_nxt   = last_beat_r;
          ws_sh_nxt   = win_start_r;
          bit_cnt_nxt = '0;
          state_nxt   = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        // timestamp rotates back into place after a full pass
        ts_sh_nxt   = {ts_sh_r[0], ts_sh_r[TS_W-1:1]};
        lb_sh_nxt   = {1'b0, lb_sh_r[TS_W-1:1]};
        ws_sh_nxt   = {1'b0, ws_sh_r[TS_W-1:1]};
        iv_sh_nxt   = {iv_bit, iv_sh_r[TS_W-1:1]};
        bit_cnt_nxt = bit_cnt_r + CNT_W'(1);
        if (bit_cnt_r == CNT_W'(TS_W - 1)) begin
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        acc_nxt    = 1'b0;
        closed_nxt = 1'b0;
        state_nxt  = ST_FINISH;
        if (act_r == ACT_BEAT) begin
          if (!refr_bw) begin
            acc_nxt       = 1'b1;
            last_iv_nxt   = iv_sh_r;
            last_beat_nxt = ts_sh_r;
            if (mode_r == MODE_COUNT) begin
              if (await_r) begin
                // first beat opens the window
                meas_nxt      = 1'b1;
                await_nxt     = 1'b0;
                fin_nxt       = 1'b0;
                win_start_nxt = ts_sh_r;
                cnt_nxt       = BPM_W'(1);
              end else if (fin_r && !gap_bw) begin
                // long pause after a finished window restarts the count
                meas_nxt      = 1'b1;
                fin_nxt       = 1'b0;
                win_start_nxt = ts_sh_r;
                cnt_nxt       = BPM_W'(1);
              end else if (meas_r) begin
                if (win_bw) begin
                  if (cnt_r != COUNT_MAX) begin
                    cnt_nxt = cnt_r + BPM_W'(1);
                  end
                end else begin
                  // late beat closes the window and is not counted
                  meas_nxt   = 1'b0;
                  fin_nxt    = 1'b1;
                  total_nxt  = cnt_r;
                  cnt_nxt    = '0;
                  closed_nxt = 1'b1;
                end
              end
            end else if (mode_r == MODE_AVERAGE) begin
              meas_nxt  = 1'b1;
              await_nxt = 1'b0;
              fin_nxt   = 1'b0;
              if (!min_bw && lim_bw) begin
                div_req.start    = 1'b1;
                div_req.dividend = RATE_NUMER;
                div_req.divisor  = iv_sh_r[DIVS_W-1:0];
                state_nxt        = ST_DIV_RATE;
              end
            end
          end
        end else if (act_r == ACT_COUNT || act_r == ACT_AVERAGE) begin
          mode_nxt  = mode_t'(act_r);
          await_nxt = 1'b1;
          meas_nxt  = 1'b0;
          fin_nxt   = 1'b0;
          if (act_r == ACT_COUNT) begin
            cnt_nxt = '0;
          end
        end
      end
      ST_DIV_RATE: begin
        if (div_rsp.done) begin
          state_nxt = ST_RING;
        end
      end
      ST_RING: begin
        // store the rate, then divide the new sum by the depth
        ring_we          = 1'b1;
        pos_nxt          = (pos_r == POS_W'(RING_DEPTH - 1)) ? '0 : pos_r + POS_W'(1);
        div_req.start    = 1'b1;
        div_req.dividend = DIVD_W'(sum_nxt);
        div_req.divisor  = DIVS_W'(RING_DEPTH);
        state_nxt        = ST_DIV_MEAN;
      end
      ST_DIV_MEAN: begin
        if (div_rsp.done) begin
          mean_nxt  = div_rsp.quotient;
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // serial operands and per-beat flags
  always_ff @(posedge clk) begin
    bit_cnt_r <= bit_cnt_nxt;
    act_r     <= act_nxt;
    ts_sh_r   <= ts_sh_nxt;
    lb_sh_r   <= lb_sh_nxt;
    ws_sh_r   <= ws_sh_nxt;
    iv_sh_r   <= iv_sh_nxt;
    acc_r     <= acc_nxt;
    closed_r  <= closed_nxt;
  end

  // tracker state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_STANDBY;
      await_r     <= 1'b1;
      meas_r      <= 1'b0;
      fin_r       <= 1'b0;
      last_beat_r <= '0;
      last_iv_r   <= '0;
      win_start_r <= '0;
      cnt_r       <= '0;
      total_r     <= '0;
      mean_r      <= '0;
      pos_r       <= '0;
      sum_r       <= '0;
    end else begin
      mode_r      <= mode_nxt;
      await_r     <= await_nxt;
      meas_r      <= meas_nxt;
      fin_r       <= fin_nxt;
      last_beat_r <= last_beat_nxt;
      last_iv_r   <= last_iv_nxt;
      win_start_r <= win_start_nxt;
      cnt_r       <= cnt_nxt;
      total_r     <= total_nxt;
      mean_r      <= mean_nxt;
      pos_r       <= pos_nxt;
      if (ring_we) begin
        sum_r <= sum_nxt;
      end
    end
  end

  // rate ring
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RING_DEPTH; i++) begin
        ring_r[i] <= '0;
      end
    end else if (ring_we) begin
      ring_r[pos_r] <= div_rsp.quotient;
    end
  end

  // rate class against the limits
  function automatic rate_class_t classify(input logic [BPM_W-1:0] r,
                                           input logic [BPM_W-1:0] hi,
                                           input logic [BPM_W-1:0] lo);
    rate_class_t c;
    if (r >= lo && r <= hi) begin
      c = CLS_NORMAL;
    end else if (r > hi && r < CLASS_CEIL) begin
      c = CLS_FAST;
    end else if (r > CLASS_FLOOR && r < lo) begin
      c = CLS_SLOW;
    end else begin
      c = CLS_NONE;
    end
    return c;
  endfunction

  always_comb begin
    if (mode_r == MODE_AVERAGE && !await_r && meas_r) begin
      cls_c = classify(mean_r, high_r, low_r);
    end else if (mode_r == MODE_COUNT && !await_r && !meas_r && fin_r) begin
      cls_c = classify(total_r, high_r, low_r);
    end else begin
      cls_c = CLS_NONE;
    end
  end

  // output register: loaded once per accepted input, held while stalled
  assign out_load = (state_r == ST_FINISH) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_mode_r   <= mode_r;
      out_acc_r    <= acc_r;
      out_iv_r     <= last_iv_r;
      out_meas_r   <= meas_r;
      out_done_r   <= fin_r;
      out_closed_r <= closed_r;
      out_cnt_r    <= cnt_r;
      out_total_r  <= total_r;
      out_mean_r   <= mean_r;
      out_cls_r    <= cls_c;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_mode              = out_mode_r;
  assign out_beat_accepted     = out_acc_r;
  assign out_interval_ms       = out_iv_r;
  assign out_measuring         = out_meas_r;
  assign out_window_done       = out_done_r;
  assign out_window_closed_now = out_closed_r;
  assign out_running_count     = out_cnt_r;
  assign out_window_total      = out_total_r;
  assign out_average_bpm       = out_mean_r;
  assign out_rate_class        = out_cls_r;

`ifndef SYNTHESIS
  // a new result only appears out of the finish step
  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FINISH))
    else $error("result raised outside finish step");

  // divider completes only while the sequencer waits on it
  a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_DIV_RATE || state_r == ST_DIV_MEAN))
    else $error("divider done while not waited on");

  // a window closes only on an accepted beat in count mode
  a_close_in_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_window_closed_now) |-> (out_beat_accepted && out_mode == MODE_COUNT))
    else $error("window closed outside count mode");

  // measuring and a held count result exclude each other
  a_meas_vs_done: assert property (@(posedge clk) disable iff (!rst_n)
    !(meas_r && fin_r))
    else $error("measuring with a finished count held");
`endif

endmodule
